### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising edge of clk outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The expression must never be true outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

### src/ocd_pkg.sv
// ----------------------------------------------------------------------------
// Overwriting circular deque package
// Widths, codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package ocd_pkg;

  localparam int MAX_DEPTH = 256;
  localparam int ADDR_W    = $clog2(MAX_DEPTH);
  localparam int CAP_W     = 9;
  localparam int DATA_W    = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 9'd100;
  localparam logic [CAP_W-1:0] CAP_MAX   = 9'(MAX_DEPTH);

  typedef enum logic [2:0] {
    FUNC_PUSH_TAIL = 3'd0,
    FUNC_PUSH_HEAD = 3'd1,
    FUNC_POP_TAIL  = 3'd2,
    FUNC_POP_HEAD  = 3'd3,
    FUNC_READ      = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FETCH
  } ctl_state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic load_rd;
  } ctl_cmd_t;

  typedef struct packed {
    logic needs_read;
  } dp_stat_t;

endpackage

### src/ocd_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One access per cycle, write or read, with registered read data.
// ----------------------------------------------------------------------------
module ocd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

### src/ocd_ctrl.sv
// ----------------------------------------------------------------------------
// Deque controller
// Sequences capture, execute and memory fetch for one word at a time.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ocd_ctrl
  import ocd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  ctl_state_t state_r;
  ctl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = stat.needs_read ? ST_FETCH : ST_IDLE;
      end
      ST_FETCH: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
      end
      ST_FETCH: begin
        cmd.load_rd = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  `ASSERT_CLK(a_fetch_after_exec, cmd.load_rd |-> $past(cmd.exec), "fetch without execute")
  `ASSERT_CLK(a_exec_after_capture, cmd.exec |-> $past(cmd.capture), "execute without capture")

endmodule

### src/ocd_dp.sv
// ----------------------------------------------------------------------------
// Deque datapath
// Capacity, head and fill registers, ring slot arithmetic, memory and
// result registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ocd_dp
  import ocd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  ctl_cmd_t                 cmd,
  output dp_stat_t                 stat,
  input  logic [2:0]               in_func,
  input  logic signed [DATA_W-1:0] in_data_in,
  input  logic [ADDR_W-1:0]        in_index,
  input  logic                     cfg_we,
  input  logic [CAP_W-1:0]         cfg_data,
  output logic                     out_strobe,
  output logic signed [DATA_W-1:0] out_data_out,
  output logic [1:0]               out_status,
  output logic                     out_dropped,
  output logic [CAP_W-1:0]         out_count
);

  function automatic logic [ADDR_W-1:0] ring_slot(
    input logic [ADDR_W-1:0] base,
    input logic [CAP_W-1:0]  offset,
    input logic [CAP_W-1:0]  cap
  );
    logic [CAP_W:0] sum;
    sum = {2'b00, base} + {1'b0, offset};
    if (sum >= {1'b0, cap}) sum = sum - {1'b0, cap};
    return sum[ADDR_W-1:0];
  endfunction

  logic [CAP_W-1:0]         cap_r;
  logic [ADDR_W-1:0]        head_r;
  logic [ADDR_W-1:0]        head_nxt;
  logic [CAP_W-1:0]         fill_r;
  logic [CAP_W-1:0]         fill_nxt;
  logic [2:0]               func_r;
  logic [DATA_W-1:0]        data_r;
  logic [ADDR_W-1:0]        index_r;

  logic [CAP_W-1:0]         cap_eff;
  logic                     full;
  logic [CAP_W-1:0]         head_inc9;
  logic [ADDR_W-1:0]        head_inc;
  logic [ADDR_W-1:0]        head_dec;
  logic [CAP_W-1:0]         fill_dec;

  logic                     ram_en;
  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_addr;
  logic [DATA_W-1:0]        ram_rdata;
  status_t                  status_c;
  logic                     dropped_c;
  logic                     needs_rd;

  logic                     out_valid_r;
  logic [DATA_W-1:0]        out_data_r;
  status_t                  out_status_r;
  logic                     out_dropped_r;
  logic [CAP_W-1:0]         out_count_r;

  always_comb begin
    if (cap_r == '0) begin
      cap_eff = 9'd1;
    end else if (cap_r > CAP_MAX) begin
      cap_eff = CAP_MAX;
    end else begin
      cap_eff = cap_r;
    end
  end

  assign full      = fill_r >= cap_eff;
  assign head_inc9 = {1'b0, head_r} + 9'd1;
  assign head_inc  = (head_inc9 >= cap_eff) ? '0 : head_inc9[ADDR_W-1:0];
  assign head_dec  = (head_r == '0) ? ADDR_W'(cap_eff - 9'd1) : head_r - 8'd1;
  assign fill_dec  = fill_r - 9'd1;

  always_comb begin
    head_nxt  = head_r;
    fill_nxt  = fill_r;
    ram_we    = 1'b0;
    ram_addr  = head_r;
    status_c  = STAT_OK;
    dropped_c = 1'b0;
    needs_rd  = 1'b0;
    unique case (func_r)
      FUNC_PUSH_TAIL: begin
        ram_we = 1'b1;
        if (full) begin
          head_nxt  = head_inc;
          dropped_c = 1'b1;
        end else begin
          ram_addr = ring_slot(head_r, fill_r, cap_eff);
          fill_nxt = fill_r + 9'd1;
        end
      end
      FUNC_PUSH_HEAD: begin
        ram_we   = 1'b1;
        ram_addr = head_dec;
        head_nxt = head_dec;
        if (full) begin
          dropped_c = 1'b1;
        end else begin
          fill_nxt = fill_r + 9'd1;
        end
      end
      FUNC_POP_TAIL: begin
        if (fill_r == '0) begin
          status_c = STAT_EMPTY;
        end else begin
          needs_rd = 1'b1;
          fill_nxt = fill_dec;
          ram_addr = ring_slot(head_r, fill_dec, cap_eff);
        end
      end
      FUNC_POP_HEAD: begin
        if (fill_r == '0) begin
          status_c = STAT_EMPTY;
        end else begin
          needs_rd = 1'b1;
          head_nxt = head_inc;
          fill_nxt = fill_dec;
        end
      end
      FUNC_READ: begin
        if ({1'b0, index_r} >= fill_r) begin
          status_c = STAT_RANGE;
        end else begin
          needs_rd = 1'b1;
          ram_addr = ring_slot(head_r, {1'b0, index_r}, cap_eff);
        end
      end
      default: begin
        needs_rd = 1'b0;
      end
    endcase
  end

  assign ram_en          = cmd.exec && (ram_we || needs_rd);
  assign stat.needs_read = needs_rd;

  ocd_ram #(
    .WIDTH(DATA_W),
    .DEPTH(MAX_DEPTH)
  ) u_ram (
    .clk  (clk),
    .en   (ram_en),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(data_r),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r  <= in_func;
      data_r  <= in_data_in;
      index_r <= in_index;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= CAP_RESET;
      head_r <= '0;
      fill_r <= '0;
    end else if (cfg_we) begin
      cap_r  <= cfg_data;
      head_r <= '0;
      fill_r <= '0;
    end else if (cmd.exec) begin
      head_r <= head_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.exec && !needs_rd) || cmd.load_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_data_r    <= '0;
      out_status_r  <= status_c;
      out_dropped_r <= dropped_c;
      out_count_r   <= fill_nxt;
    end else if (cmd.load_rd) begin
      out_data_r <= ram_rdata;
    end
  end

  assign out_strobe   = out_valid_r;
  assign out_data_out = out_data_r;
  assign out_status   = out_status_r;
  assign out_dropped  = out_dropped_r;
  assign out_count    = out_count_r;

  `ASSERT_NEVER(a_fill_in_cap, fill_r > cap_eff, "fill exceeds capacity")
  `ASSERT_NEVER(a_head_in_cap, {1'b0, head_r} >= cap_eff, "head beyond capacity")
  `ASSERT_CLK(a_strobe_single, out_valid_r |=> !out_valid_r, "back to back result strobes")

endmodule

### src/overwriting_circular_deque.sv
// ----------------------------------------------------------------------------
// Overwriting circular deque
// Push, pop and indexed read on a ring of signed words; a full ring drops
// one entry on push.
// out_strobe is registered: it follows the execute state for pushes, errors
// and unused codes, and the fetch state for successful pops and reads.
// Words are taken one at a time; busy stays high through execute and, when a
// word reads the single port memory with its registered read, through fetch.
// Reset clears head and fill and sets capacity to 100; memory contents stay
// undefined until written. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module overwriting_circular_deque
  import ocd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [2:0]               in_func,
  input  logic signed [DATA_W-1:0] in_data_in,
  input  logic [ADDR_W-1:0]        in_index,
  input  logic                     cfg_we,
  input  logic [CAP_W-1:0]         cfg_data,
  output logic                     out_strobe,
  output logic signed [DATA_W-1:0] out_data_out,
  output logic [1:0]               out_status,
  output logic                     out_dropped,
  output logic [CAP_W-1:0]         out_count
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  ocd_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .busy (busy),
    .stat (stat),
    .cmd  (cmd)
  );

  ocd_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_func     (in_func),
    .in_data_in  (in_data_in),
    .in_index    (in_index),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .out_strobe  (out_strobe),
    .out_data_out(out_data_out),
    .out_status  (out_status),
    .out_dropped (out_dropped),
    .out_count   (out_count)
  );

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// Overwriting circular deque testbench
// Drives push, pop, indexed read and spare operation words through the
// start/busy handshake and checks every result word against directed or
// in-bench ring model expectations. A directed table covers the empty and
// full extremes and the out-of-range capacities, then random segments
// sweep several capacities, push/pop-heavy mixes and sender gap rates.
// ----------------------------------------------------------------------------
module testbench;
  import ocd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] FUNC_SPARE_LO = FUNC_READ + 3'd1;
  localparam logic [2:0] FUNC_SPARE_HI = 3'b111;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic [1:0]               status;
    logic                     dropped;
    logic [CAP_W-1:0]         count;
  } reply_t;

  typedef struct {
    bit                       is_cfg;
    bit                       typed;
    logic [2:0]               func;
    logic signed [DATA_W-1:0] data;
    logic [ADDR_W-1:0]        index;
    logic [CAP_W-1:0]         cap;
    reply_t                   reply;
  } step_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [2:0]               in_func = '0;
  logic signed [DATA_W-1:0] in_data_in = '0;
  logic [ADDR_W-1:0]        in_index = '0;
  logic                     cfg_we = 1'b0;
  logic [CAP_W-1:0]         cfg_data = '0;
  logic                     out_strobe;
  logic signed [DATA_W-1:0] out_data_out;
  logic [1:0]               out_status;
  logic                     out_dropped;
  logic [CAP_W-1:0]         out_count;

  logic signed [DATA_W-1:0] ring_mem [0:MAX_DEPTH-1];
  int                       ring_head;
  int                       ring_fill;
  logic [CAP_W-1:0]         ring_cap;

  reply_t                   due_replies[$];
  step_t                    directed_steps[$];
  int                       sender_gap_pct;
  int                       mismatches;
  int                       words_sent;
  int                       words_checked;
  int                       drops_seen;
  int                       errors_seen;
  int                       caps_written;

  always #2 clk = ~clk;

  overwriting_circular_deque dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_func      (in_func),
    .in_data_in   (in_data_in),
    .in_index     (in_index),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .out_strobe   (out_strobe),
    .out_data_out (out_data_out),
    .out_status   (out_status),
    .out_dropped  (out_dropped),
    .out_count    (out_count)
  );

  function automatic int ring_span();
    int cap;
    cap = int'(ring_cap);
    if (cap == 0) cap = 1;
    if (cap > MAX_DEPTH) cap = MAX_DEPTH;
    return cap;
  endfunction

  function automatic reply_t ring_apply(logic [2:0] func, logic signed [DATA_W-1:0] data,
                                        logic [ADDR_W-1:0] index);
    reply_t r;
    int     cap;
    cap = ring_span();
    r = '0;
    if (ring_fill > cap) ring_fill = cap;
    if (ring_head >= cap) ring_head = ring_head % cap;
    case (func)
      FUNC_PUSH_TAIL: begin
        if (ring_fill >= cap) begin
          ring_mem[ring_head] = data;
          ring_head = (ring_head + 1) % cap;
          r.dropped = 1'b1;
        end else begin
          ring_mem[(ring_head + ring_fill) % cap] = data;
          ring_fill++;
        end
      end
      FUNC_PUSH_HEAD: begin
        ring_head = (ring_head + cap - 1) % cap;
        ring_mem[ring_head] = data;
        if (ring_fill >= cap) r.dropped = 1'b1;
        else ring_fill++;
      end
      FUNC_POP_TAIL: begin
        if (ring_fill == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          ring_fill--;
          r.data = ring_mem[(ring_head + ring_fill) % cap];
        end
      end
      FUNC_POP_HEAD: begin
        if (ring_fill == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.data = ring_mem[ring_head];
          ring_head = (ring_head + 1) % cap;
          ring_fill--;
        end
      end
      FUNC_READ: begin
        if (int'(index) >= ring_fill) r.status = STAT_RANGE;
        else r.data = ring_mem[(ring_head + int'(index)) % cap];
      end
      default: begin
      end
    endcase
    r.count = CAP_W'(ring_fill);
    return r;
  endfunction

  task automatic flag_mismatch(string msg);
    if (mismatches < 40) $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic send_word(logic [2:0] func, logic signed [DATA_W-1:0] data,
                           logic [ADDR_W-1:0] index, bit typed, reply_t typed_reply);
    reply_t predicted;
    while ($urandom_range(0, 99) < sender_gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    in_func    <= func;
    in_data_in <= data;
    in_index   <= index;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    predicted = ring_apply(func, data, index);
    due_replies.insert(due_replies.size(), typed ? typed_reply : predicted);
    words_sent++;
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] value);
    start <= 1'b0;
    while (due_replies.size() != 0 || busy !== 1'b0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    ring_cap  = value;
    ring_head = 0;
    ring_fill = 0;
    caps_written++;
  endtask

  function automatic void add_op(logic [2:0] func, logic signed [DATA_W-1:0] data,
                                 logic [ADDR_W-1:0] index);
    step_t s;
    s = '{default: '0};
    s.func  = func;
    s.data  = data;
    s.index = index;
    directed_steps.insert(directed_steps.size(), s);
  endfunction

  function automatic void add_checked(logic [2:0] func, logic signed [DATA_W-1:0] data,
                                      logic [ADDR_W-1:0] index, logic signed [DATA_W-1:0] rdata,
                                      logic [1:0] status, logic dropped, int count);
    step_t s;
    s = '{default: '0};
    s.typed = 1'b1;
    s.func  = func;
    s.data  = data;
    s.index = index;
    s.reply = '{data: rdata, status: status, dropped: dropped, count: CAP_W'(count)};
    directed_steps.insert(directed_steps.size(), s);
  endfunction

  function automatic void add_cfg(logic [CAP_W-1:0] value);
    step_t s;
    s = '{default: '0};
    s.is_cfg = 1'b1;
    s.cap    = value;
    directed_steps.insert(directed_steps.size(), s);
  endfunction

  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_strobe === 1'b1) begin
      if (due_replies.size() == 0) begin
        flag_mismatch("result word with no expectation pending");
      end else begin
        want = due_replies[0];
        due_replies.delete(0);
        if (out_data_out !== want.data)
          flag_mismatch($sformatf("data_out %h, expected %h", out_data_out, want.data));
        if (out_status !== want.status)
          flag_mismatch($sformatf("status %0d, expected %0d", out_status, want.status));
        if (out_dropped !== want.dropped)
          flag_mismatch($sformatf("dropped %b, expected %b", out_dropped, want.dropped));
        if (out_count !== want.count)
          flag_mismatch($sformatf("count %0d, expected %0d", out_count, want.count));
        words_checked++;
        if (want.dropped) drops_seen++;
        if (want.status != STAT_OK) errors_seen++;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Timeout: result words still outstanding.");
    $display("testbench failed");
    $finish;
  end

  initial begin
    step_t            s;
    int               seg;
    int               seg_len;
    int               n;
    int               roll;
    int               push_lim;
    int               pop_lim;
    int               read_lim;
    int               waited;
    logic [CAP_W-1:0] seg_cap;
    logic [2:0]       func;
    logic signed [DATA_W-1:0] data;
    logic [ADDR_W-1:0] index;

    ring_cap       = CAP_RESET;
    ring_head      = 0;
    ring_fill      = 0;
    sender_gap_pct = 26;
    foreach (ring_mem[i]) ring_mem[i] = '0;

    add_checked(FUNC_POP_TAIL,  0, 0, 0, STAT_EMPTY, 0, 0);
    add_checked(FUNC_POP_HEAD,  0, 0, 0, STAT_EMPTY, 0, 0);
    add_checked(FUNC_READ,      0, 0, 0, STAT_RANGE, 0, 0);
    add_checked(FUNC_SPARE_LO,  32'h7fffffff, 8'hff, 0, STAT_OK, 0, 0);
    add_checked(FUNC_SPARE_HI,  32'h80000000, 8'hff, 0, STAT_OK, 0, 0);
    add_checked(FUNC_PUSH_TAIL, 32'h7fffffff, 0, 0, STAT_OK, 0, 1);
    add_checked(FUNC_PUSH_HEAD, 32'h80000000, 0, 0, STAT_OK, 0, 2);
    add_checked(FUNC_READ,      0, 0, 32'h80000000, STAT_OK, 0, 2);
    add_checked(FUNC_READ,      0, 8'hff, 0, STAT_RANGE, 0, 2);
    add_checked(FUNC_SPARE_LO + 3'd1, 32'hffffffff, 0, 0, STAT_OK, 0, 2);
    add_checked(FUNC_POP_TAIL,  0, 0, 32'h7fffffff, STAT_OK, 0, 1);
    add_checked(FUNC_POP_HEAD,  0, 0, 32'h80000000, STAT_OK, 0, 0);
    add_cfg(9'd1);
    add_checked(FUNC_PUSH_TAIL, 32'hffffffff, 0, 0, STAT_OK, 0, 1);
    add_checked(FUNC_PUSH_TAIL, 32'h00000001, 0, 0, STAT_OK, 1, 1);
    add_checked(FUNC_PUSH_HEAD, 32'h55555555, 0, 0, STAT_OK, 1, 1);
    add_checked(FUNC_READ,      0, 0, 32'h55555555, STAT_OK, 0, 1);
    add_checked(FUNC_POP_TAIL,  0, 0, 32'h55555555, STAT_OK, 0, 0);
    add_cfg(9'd0);
    add_checked(FUNC_PUSH_TAIL, 32'haaaaaaaa, 0, 0, STAT_OK, 0, 1);
    add_checked(FUNC_PUSH_HEAD, 32'h00000000, 0, 0, STAT_OK, 1, 1);
    add_checked(FUNC_POP_HEAD,  0, 0, 32'h00000000, STAT_OK, 0, 0);
    add_cfg(9'h1ff);
    add_checked(FUNC_PUSH_HEAD, 32'h12345678, 0, 0, STAT_OK, 0, 1);
    add_cfg(9'd2);
    add_op(FUNC_PUSH_TAIL, 32'h00000001, 0);
    add_op(FUNC_PUSH_TAIL, 32'h00000002, 0);
    add_op(FUNC_PUSH_TAIL, 32'h00000003, 0);
    add_op(FUNC_READ, 0, 8'd1);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_steps[i]) begin
      s = directed_steps[i];
      if (s.is_cfg) write_capacity(s.cap);
      else send_word(s.func, s.data, s.index, s.typed, s.reply);
    end

    for (seg = 0; seg < 12; seg++) begin
      case (seg)
        0:       begin seg_cap = 9'd256; seg_len = 420; end
        1:       begin seg_cap = 9'd1;   seg_len = 60;  end
        2:       begin seg_cap = 9'd5;   seg_len = 70;  end
        3:       begin seg_cap = CAP_W'($urandom_range(2, 16));    seg_len = 70; end
        4:       begin seg_cap = CAP_RESET; seg_len = 90; end
        5:       begin seg_cap = 9'd0;   seg_len = 40;  end
        6:       begin seg_cap = CAP_W'($urandom_range(257, 511)); seg_len = 70; end
        7:       begin seg_cap = 9'd3;   seg_len = 50;  end
        8:       begin seg_cap = CAP_W'($urandom_range(1, 256));   seg_len = 80; end
        9:       begin seg_cap = 9'd2;   seg_len = 50;  end
        10:      begin seg_cap = 9'd7;   seg_len = 50;  end
        default: begin seg_cap = CAP_W'($urandom_range(1, 32));    seg_len = 50; end
      endcase
      sender_gap_pct = (seg < 4) ? 26 : (seg < 8) ? 59 : 0;
      write_capacity(seg_cap);
      for (n = 0; n < seg_len; n++) begin
        if (ring_span() >= 64 && n < seg_len * 4 / 5) begin
          push_lim = 90; pop_lim = 93; read_lim = 98;
        end else if (ring_span() >= 64) begin
          push_lim = 20; pop_lim = 75; read_lim = 95;
        end else begin
          push_lim = 45; pop_lim = 75; read_lim = 95;
        end
        roll = $urandom_range(0, 99);
        if (roll < push_lim)
          func = $urandom_range(0, 1) ? FUNC_PUSH_HEAD : FUNC_PUSH_TAIL;
        else if (roll < pop_lim)
          func = $urandom_range(0, 1) ? FUNC_POP_HEAD : FUNC_POP_TAIL;
        else if (roll < read_lim)
          func = FUNC_READ;
        else
          func = 3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
        case ($urandom_range(0, 19))
          0:       data = 32'h00000000;
          1:       data = 32'hffffffff;
          2:       data = 32'h80000000;
          3:       data = 32'h7fffffff;
          default: data = $urandom;
        endcase
        if (ring_fill > 0 && $urandom_range(0, 3) != 0)
          index = ADDR_W'($urandom_range(0, ring_fill - 1));
        else
          index = ADDR_W'($urandom_range(0, 255));
        send_word(func, data, index, 1'b0, '0);
      end
    end

    start <= 1'b0;
    waited = 0;
    while (due_replies.size() != 0 && waited < 200) begin
      @(posedge clk);
      waited++;
    end
    repeat (6) @(posedge clk);
    if (due_replies.size() != 0)
      flag_mismatch($sformatf("%0d expected result words never arrived", due_replies.size()));

    $display("Run covered %0d words and %0d checked results over %0d capacity settings,",
             words_sent, words_checked, caps_written);
    $display("including %0d pushes that dropped an entry and %0d error statuses.",
             drops_seen, errors_seen);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/ocd_pkg.sv
src/ocd_ram.sv
src/ocd_ctrl.sv
src/ocd_dp.sv
src/overwriting_circular_deque.sv
test/testbench.sv
